/* design/slater_condon_matrix_element_macros.svh */
// Assertion macros for the Slater-Condon matrix element checker.
`ifndef SLATER_CONDON_MATRIX_ELEMENT_MACROS_SVH
`define SLATER_CONDON_MATRIX_ELEMENT_MACROS_SVH
// Consequent must hold in the same cycle, checked outside reset.
`define SCME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the following cycle, checked outside reset.
`define SCME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Consequent must hold in the following cycle, also across reset.
`define SCME_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

/* design/scme_pkg.sv */
// Types, constants and arithmetic helpers shared by the matrix element design.
package scme_pkg;

  localparam int NUM_ORBITALS_DEFAULT = 16;
  localparam int MASK_W = 16;
  localparam int ORB_W = 4;
  localparam int IDX_W = 5;
  localparam int VALUE_W = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_LOAD_ONE = 2'd0;
  localparam logic [1:0] KIND_LOAD_TWO = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam value_t VALUE_MIN = value_t'({1'b1, {(VALUE_W-1){1'b0}}});
  localparam value_t VALUE_MAX = value_t'({1'b0, {(VALUE_W-1){1'b1}}});

  typedef struct packed {
    logic [1:0] kind;
    logic [ORB_W-1:0] orb_p;
    logic [ORB_W-1:0] orb_q;
    logic [ORB_W-1:0] orb_r;
    logic [ORB_W-1:0] orb_s;
    logic signed [VALUE_W-1:0] integral_value;
    logic [MASK_W-1:0] alpha_left;
    logic [MASK_W-1:0] beta_left;
    logic [MASK_W-1:0] alpha_right;
    logic [MASK_W-1:0] beta_right;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] matrix_element;
    logic [1:0] excitation_level;
    logic count_mismatch;
  } result_t;

  typedef enum logic [2:0] {
    OP_LOAD_ONE,
    OP_LOAD_TWO,
    OP_DIAG,
    OP_SINGLE,
    OP_DOUBLE,
    OP_MIXED,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t op;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] s;
    logic [MASK_W-1:0] ma;
    logic [MASK_W-1:0] mb;
    logic neg;
    logic [1:0] level;
    logic mismatch;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic value_t sat_add(value_t a, value_t b);
    logic [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end
    return s[VALUE_W-1:0];
  endfunction

  function automatic value_t sat_sub(value_t a, value_t b);
    logic [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end
    return s[VALUE_W-1:0];
  endfunction

  function automatic value_t sat_neg(value_t a);
    return (a == VALUE_MIN) ? VALUE_MAX : -a;
  endfunction

  function automatic value_t half_floor(value_t a);
    return {a[VALUE_W-1], a[VALUE_W-1:1]};
  endfunction

  function automatic logic [ORB_W:0] popcount(logic [MASK_W-1:0] m);
    logic [ORB_W:0] c;
    c = '0;
    for (int i = 0; i < MASK_W; i++) begin
      c = c + (ORB_W+1)'(m[i]);
    end
    return c;
  endfunction

  function automatic logic [ORB_W-1:0] lowest_bit(logic [MASK_W-1:0] m);
    logic [ORB_W-1:0] r;
    r = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = ORB_W'(i);
      end
    end
    return r;
  endfunction

  // Parity of the occupied orbitals strictly between a and b.
  function automatic logic odd_between(logic [MASK_W-1:0] m, logic [ORB_W-1:0] a,
                                       logic [ORB_W-1:0] b);
    logic [ORB_W-1:0] lo;
    logic [ORB_W-1:0] hi;
    logic par;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    par = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i > int'(lo) && i < int'(hi)) begin
        par = par ^ m[i];
      end
    end
    return par;
  endfunction

endpackage

/* design/scme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scme_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/scme_front.sv */
// Front end: accepts input words and classifies them into commands.
module scme_front #(
  parameter int NUM_ORBITALS = scme_pkg::NUM_ORBITALS_DEFAULT
) (
  input  logic                   item_valid,
  output logic                   item_stall,
  input  scme_pkg::item_t        item,
  input  scme_pkg::back_status_t status,
  input  logic                   queue_full,
  output logic                   push,
  output scme_pkg::cmd_t         cmd
);

  import scme_pkg::*;

  localparam logic [MASK_W-1:0] ORB_MASK = (NUM_ORBITALS >= MASK_W) ?
    {MASK_W{1'b1}} : MASK_W'((1 << NUM_ORBITALS) - 1);

  logic [MASK_W-1:0] al, bl, ar, br;
  logic [MASK_W-1:0] occ_a, vir_a, occ_b, vir_b;
  logic [ORB_W:0] na, nb;
  logic [ORB_W+1:0] level;
  logic mismatch;
  logic load_one_ok, load_two_ok;
  logic [ORB_W-1:0] pa, qa, ra, sa, pb, qb, rb, sb;

  always_comb begin
    al = item.alpha_left & ORB_MASK;
    bl = item.beta_left & ORB_MASK;
    ar = item.alpha_right & ORB_MASK;
    br = item.beta_right & ORB_MASK;
    occ_a = al & ~ar;
    vir_a = ar & ~al;
    occ_b = bl & ~br;
    vir_b = br & ~bl;
    na = popcount(occ_a);
    nb = popcount(occ_b);
    level = {1'b0, na} + {1'b0, nb};
    mismatch = (popcount(al) != popcount(ar)) || (popcount(bl) != popcount(br));
    pa = lowest_bit(occ_a);
    ra = lowest_bit(occ_a & ~(MASK_W'(1) << pa));
    qa = lowest_bit(vir_a);
    sa = lowest_bit(vir_a & ~(MASK_W'(1) << qa));
    pb = lowest_bit(occ_b);
    rb = lowest_bit(occ_b & ~(MASK_W'(1) << pb));
    qb = lowest_bit(vir_b);
    sb = lowest_bit(vir_b & ~(MASK_W'(1) << qb));
    load_one_ok = (int'(item.orb_p) < NUM_ORBITALS) && (int'(item.orb_q) < NUM_ORBITALS);
    load_two_ok = load_one_ok && (int'(item.orb_r) < NUM_ORBITALS) &&
                  (int'(item.orb_s) < NUM_ORBITALS);

    cmd = '0;
    cmd.op = OP_ZERO;
    cmd.value = item.integral_value;
    cmd.p = IDX_W'(item.orb_p);
    cmd.q = IDX_W'(item.orb_q);
    cmd.r = IDX_W'(item.orb_r);
    cmd.s = IDX_W'(item.orb_s);
    cmd.ma = al;
    cmd.mb = bl;
    cmd.level = (level > (ORB_W+2)'(2)) ? 2'd3 : level[1:0];
    cmd.mismatch = mismatch;
    case (item.kind)
      KIND_LOAD_ONE: cmd.op = OP_LOAD_ONE;
      KIND_LOAD_TWO: cmd.op = OP_LOAD_TWO;
      KIND_COMPUTE: begin
        if (!mismatch) begin
          if (al == ar && bl == br) begin
            cmd.op = OP_DIAG;
          end else if (level == (ORB_W+2)'(1) && na == (ORB_W+1)'(1)) begin
            cmd.op = OP_SINGLE;
            cmd.p = IDX_W'(pa);
            cmd.q = IDX_W'(qa);
            cmd.neg = odd_between(al, pa, qa);
          end else if (level == (ORB_W+2)'(1)) begin
            cmd.op = OP_SINGLE;
            cmd.p = IDX_W'(pb);
            cmd.q = IDX_W'(qb);
            cmd.ma = bl;
            cmd.mb = al;
            cmd.neg = odd_between(bl, pb, qb);
          end else if (level == (ORB_W+2)'(2) && na == (ORB_W+1)'(2)) begin
            cmd.op = OP_DOUBLE;
            cmd.p = IDX_W'(pa);
            cmd.q = IDX_W'(qa);
            cmd.r = IDX_W'(ra);
            cmd.s = IDX_W'(sa);
            cmd.neg = odd_between(al, pa, qa) ^ odd_between(ar, ra, sa);
          end else if (level == (ORB_W+2)'(2) && nb == (ORB_W+1)'(2)) begin
            cmd.op = OP_DOUBLE;
            cmd.p = IDX_W'(pb);
            cmd.q = IDX_W'(qb);
            cmd.r = IDX_W'(rb);
            cmd.s = IDX_W'(sb);
            cmd.neg = odd_between(bl, pb, qb) ^ odd_between(br, rb, sb);
          end else if (level == (ORB_W+2)'(2)) begin
            cmd.op = OP_MIXED;
            cmd.p = IDX_W'(pa);
            cmd.q = IDX_W'(qa);
            cmd.r = IDX_W'(pb);
            cmd.s = IDX_W'(qb);
            cmd.neg = odd_between(al, pa, qa) ^ odd_between(bl, pb, qb);
          end
        end
      end
      default: cmd.op = OP_ZERO;
    endcase
  end

  assign item_stall = queue_full || status.clearing;
  assign push = item_valid && !item_stall &&
                ((item.kind == KIND_LOAD_ONE && load_one_ok) ||
                 (item.kind == KIND_LOAD_TWO && load_two_ok) ||
                 (item.kind == KIND_COMPUTE));

endmodule

/* design/scme_queue.sv */
// Short command queue between the front end and the back end.
module scme_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scme_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output scme_pkg::cmd_t head
);

  import scme_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full = (count == (PW+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head = slots[rd_ptr];

endmodule

/* design/scme_back.sv */
// Back end: integral tables, clearing pass and the Slater-Condon sequencer.
module scme_back #(
  parameter int NUM_ORBITALS = scme_pkg::NUM_ORBITALS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  scme_pkg::cmd_t         q_cmd,
  output logic                   pop,
  output scme_pkg::back_status_t status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output scme_pkg::result_t      result
);

  import scme_pkg::*;

  localparam int OB = (NUM_ORBITALS > 1) ? $clog2(NUM_ORBITALS) : 1;
  localparam int A1 = 2 * OB;
  localparam int A2 = 4 * OB;
  localparam int D1 = 1 << A1;
  localparam int D2 = 1 << A2;
  localparam logic [OB-1:0] LAST = OB'(NUM_ORBITALS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD_ONE, ST_LOAD_TWO,
    ST_DIAG_P, ST_DIAG_H, ST_DIAG_Q, ST_DIAG_X, ST_DIAG_D, ST_DIAG_A, ST_DIAG_B,
    ST_SGL_R, ST_SGL_X, ST_SGL_D, ST_SGL_A, ST_SGL_B, ST_SGL_H, ST_SGL_S,
    ST_PAIR_A, ST_PAIR_B, ST_PAIR_D, ST_FIN, ST_OUT
  } state_t;

  state_t state;
  cmd_t cur;
  value_t acc, ta, tb, r1, r2, wdata;
  logic [NUM_ORBITALS-1:0] ma, mb, dsame, dother;
  logic [OB-1:0] pidx, qidx, cp, cq, cr, cs;
  logic spin;
  logic [2:0] k;
  logic [A2-1:0] clr;
  logic we1, we2;
  logic [A1-1:0] waddr1, raddr1;
  logic [A2-1:0] waddr2, raddr2;
  logic diag_done;

  assign cp = cur.p[OB-1:0];
  assign cq = cur.q[OB-1:0];
  assign cr = cur.r[OB-1:0];
  assign cs = cur.s[OB-1:0];
  assign dsame = spin ? mb : ma;
  assign dother = spin ? ma : mb;
  assign diag_done = spin && (pidx == LAST);
  assign pop = (state == ST_IDLE) && q_valid;
  assign status.clearing = (state == ST_CLEAR);

  always_comb begin
    we1 = 1'b0;
    we2 = 1'b0;
    waddr1 = clr[A1-1:0];
    waddr2 = clr;
    wdata = '0;
    raddr1 = {cp, cq};
    raddr2 = {cp, cq, cr, cs};
    case (state)
      ST_CLEAR: begin
        we1 = 1'b1;
        we2 = 1'b1;
      end
      ST_LOAD_ONE: begin
        we1 = 1'b1;
        wdata = cur.value;
        waddr1 = k[0] ? {cq, cp} : {cp, cq};
      end
      ST_LOAD_TWO: begin
        we2 = 1'b1;
        wdata = cur.value;
        case (k)
          3'd0: waddr2 = {cp, cq, cr, cs};
          3'd1: waddr2 = {cp, cq, cs, cr};
          3'd2: waddr2 = {cq, cp, cr, cs};
          3'd3: waddr2 = {cq, cp, cs, cr};
          3'd4: waddr2 = {cr, cs, cp, cq};
          3'd5: waddr2 = {cr, cs, cq, cp};
          3'd6: waddr2 = {cs, cr, cp, cq};
          default: waddr2 = {cs, cr, cq, cp};
        endcase
      end
      ST_DIAG_P: raddr1 = {pidx, pidx};
      ST_DIAG_Q: raddr2 = {pidx, qidx, pidx, qidx};
      ST_DIAG_X: raddr2 = {pidx, pidx, qidx, qidx};
      ST_SGL_R: raddr2 = {cp, cq, qidx, qidx};
      ST_SGL_X: raddr2 = {cp, qidx, qidx, cq};
      ST_SGL_H: raddr1 = {cp, cq};
      ST_PAIR_A: raddr2 = {cp, cq, cr, cs};
      ST_PAIR_B: raddr2 = {cp, cs, cr, cq};
      default: ;
    endcase
  end

  scme_ram #(.WIDTH(VALUE_W), .DEPTH(D1)) u_one_electron (
    .clk(clk), .we(we1), .waddr(waddr1), .wdata(wdata), .raddr(raddr1), .rdata(r1)
  );

  scme_ram #(.WIDTH(VALUE_W), .DEPTH(D2)) u_two_electron (
    .clk(clk), .we(we2), .waddr(waddr2), .wdata(wdata), .raddr(raddr2), .rdata(r2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != ST_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_cmd;
            ma <= NUM_ORBITALS'(q_cmd.ma);
            mb <= NUM_ORBITALS'(q_cmd.mb);
            acc <= '0;
            pidx <= '0;
            qidx <= '0;
            spin <= 1'b0;
            k <= '0;
            case (q_cmd.op)
              OP_LOAD_ONE: state <= ST_LOAD_ONE;
              OP_LOAD_TWO: state <= ST_LOAD_TWO;
              OP_DIAG: state <= ST_DIAG_P;
              OP_SINGLE: state <= ST_SGL_R;
              OP_DOUBLE, OP_MIXED: state <= ST_PAIR_A;
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_LOAD_ONE: begin
          k <= k + 1'b1;
          if (k[0]) begin
            state <= ST_IDLE;
          end
        end
        ST_LOAD_TWO: begin
          k <= k + 1'b1;
          if (k == 3'd7) begin
            state <= ST_IDLE;
          end
        end
        ST_DIAG_P: begin
          if (dsame[pidx]) begin
            state <= ST_DIAG_H;
          end else begin
            spin <= ~spin;
            if (spin) begin
              pidx <= pidx + 1'b1;
            end
            state <= diag_done ? ST_FIN : ST_DIAG_P;
          end
        end
        ST_DIAG_H: begin
          acc <= sat_add(acc, r1);
          qidx <= '0;
          state <= ST_DIAG_Q;
        end
        ST_DIAG_Q: begin
          if (dsame[qidx] || dother[qidx]) begin
            state <= ST_DIAG_X;
          end else if (qidx == LAST) begin
            spin <= ~spin;
            if (spin) begin
              pidx <= pidx + 1'b1;
            end
            state <= diag_done ? ST_FIN : ST_DIAG_P;
          end else begin
            qidx <= qidx + 1'b1;
          end
        end
        ST_DIAG_X: begin
          ta <= r2;
          state <= ST_DIAG_D;
        end
        ST_DIAG_D: begin
          tb <= r2;
          ta <= half_floor(sat_sub(r2, ta));
          state <= ST_DIAG_A;
        end
        ST_DIAG_A: begin
          if (dsame[qidx]) begin
            acc <= sat_add(acc, ta);
          end
          state <= ST_DIAG_B;
        end
        ST_DIAG_B: begin
          if (dother[qidx]) begin
            acc <= sat_add(acc, half_floor(tb));
          end
          if (qidx == LAST) begin
            spin <= ~spin;
            if (spin) begin
              pidx <= pidx + 1'b1;
            end
            state <= diag_done ? ST_FIN : ST_DIAG_P;
          end else begin
            qidx <= qidx + 1'b1;
            state <= ST_DIAG_Q;
          end
        end
        ST_SGL_R: begin
          if (ma[qidx] || mb[qidx]) begin
            state <= ST_SGL_X;
          end else if (qidx == LAST) begin
            state <= ST_SGL_H;
          end else begin
            qidx <= qidx + 1'b1;
          end
        end
        ST_SGL_X: begin
          ta <= r2;
          state <= ST_SGL_D;
        end
        ST_SGL_D: begin
          tb <= r2;
          if (ma[qidx]) begin
            acc <= sat_add(acc, ta);
          end
          state <= ST_SGL_A;
        end
        ST_SGL_A: begin
          if (ma[qidx]) begin
            acc <= sat_sub(acc, tb);
          end
          state <= ST_SGL_B;
        end
        ST_SGL_B: begin
          if (mb[qidx]) begin
            acc <= sat_add(acc, ta);
          end
          if (qidx == LAST) begin
            state <= ST_SGL_H;
          end else begin
            qidx <= qidx + 1'b1;
            state <= ST_SGL_R;
          end
        end
        ST_SGL_H: state <= ST_SGL_S;
        ST_SGL_S: begin
          acc <= sat_add(r1, acc);
          state <= ST_FIN;
        end
        ST_PAIR_A: state <= ST_PAIR_B;
        ST_PAIR_B: begin
          ta <= r2;
          if (cur.op == OP_MIXED) begin
            acc <= r2;
            state <= ST_FIN;
          end else begin
            state <= ST_PAIR_D;
          end
        end
        ST_PAIR_D: begin
          acc <= sat_sub(ta, r2);
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (cur.neg) begin
            acc <= sat_neg(acc);
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!result_valid || !result_stall) begin
            result.matrix_element <= acc;
            result.excitation_level <= cur.level;
            result.count_mismatch <= cur.mismatch;
            result_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/slater_condon_matrix_element.sv */
// Top level of the Slater-Condon Hamiltonian matrix element block.
//
// Channel  Dir  Payload   Word taken when
// item     in   item_t    item_valid && !item_stall
// result   out  result_t  result_valid && !result_stall
//
// A one-electron load writes two table entries and a two-electron load eight, one table write per cycle.
// A diagonal element steps through every spin-orbital p and, for each occupied p, scans every
// orbital q, paced by the single read port of the two-electron table.
// A single excitation scans every orbital and reads two integrals per occupied orbital;
// same-spin doubles read two integrals, alpha-beta doubles one and zero elements none.
// After reset a clearing pass over all 2^(4*ceil(log2 NUM_ORBITALS)) addresses (65536 at 16
// orbitals) zeroes both tables; item_stall stays high meanwhile.
// Results wait in an output register; a two-word queue keeps the front accepting.
module slater_condon_matrix_element #(
  parameter int NUM_ORBITALS = scme_pkg::NUM_ORBITALS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  scme_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output scme_pkg::result_t result
);

  import scme_pkg::*;

  cmd_t push_cmd, head;
  logic push, pop, full, nonempty;
  back_status_t status;

  scme_front #(.NUM_ORBITALS(NUM_ORBITALS)) u_front (
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .status(status),
    .queue_full(full),
    .push(push),
    .cmd(push_cmd)
  );

  scme_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .full(full),
    .pop(pop),
    .nonempty(nonempty),
    .head(head)
  );

  scme_back #(.NUM_ORBITALS(NUM_ORBITALS)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(nonempty),
    .q_cmd(head),
    .pop(pop),
    .status(status),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

endmodule

/* design/scme_checker.sv */
// Port-level checker for the matrix element block, bound to the top level.
`include "slater_condon_matrix_element_macros.svh"

module scme_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input scme_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input scme_pkg::result_t result
);

  `SCME_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result word changed")
  `SCME_ASSERT_ALWAYS(a_clear_stall, clk, rst, item_stall, "input taken during table clearing")
  `SCME_ASSERT_NOW(a_mismatch_zero, clk, rst, result_valid && result.count_mismatch, result.matrix_element == 0, "nonzero element on count mismatch")
  `SCME_ASSERT_NOW(a_far_zero, clk, rst, result_valid && result.excitation_level == 2'd3, result.matrix_element == 0, "nonzero element beyond double excitation")

endmodule

bind slater_condon_matrix_element scme_checker u_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the Slater-Condon matrix element block with its own integral tables.
`timescale 1ns / 1ps

module tb_top;
  import scme_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] LEVEL_MANY = 2'd3;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int TAIL_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 700;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;

  slater_condon_matrix_element i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  value_t one_tab [256];
  value_t two_tab [65536];
  item_t pending_words [$];
  bit drain_before [$];
  result_t expected_elements [$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int level_seen [4];
  longint cycles = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic value_t add_sat(value_t a, value_t b);
    value_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? VALUE_MIN : VALUE_MAX;
    return r;
  endfunction

  function automatic value_t sub_sat(value_t a, value_t b);
    value_t r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? VALUE_MIN : VALUE_MAX;
    return r;
  endfunction

  function automatic value_t neg_sat(value_t a);
    return (a == VALUE_MIN) ? VALUE_MAX : -a;
  endfunction

  function automatic value_t halve(value_t a);
    return a >>> 1;
  endfunction

  function automatic int low_index(logic [15:0] m);
    for (int i = 0; i < 16; i++) if (m[i]) return i;
    return 0;
  endfunction

  function automatic bit parity_between(logic [15:0] m, int a, int b);
    bit par;
    par = 0;
    for (int i = 0; i < 16; i++) if (i > (a < b ? a : b) && i < (a < b ? b : a)) par ^= m[i];
    return par;
  endfunction

  function automatic value_t g(int p, int q, int r, int s);
    return two_tab[{p[3:0], q[3:0], r[3:0], s[3:0]}];
  endfunction

  function automatic value_t diagonal_energy(logic [15:0] al, logic [15:0] be);
    value_t v;
    v = '0;
    for (int p = 0; p < 16; p++) begin
      for (int spin = 0; spin < 2; spin++) begin
        logic [15:0] same;
        logic [15:0] other;
        same = spin ? be : al;
        other = spin ? al : be;
        if (same[p]) begin
          v = add_sat(v, one_tab[{p[3:0], p[3:0]}]);
          for (int q = 0; q < 16; q++) begin
            if (same[q]) v = add_sat(v, halve(sub_sat(g(p, p, q, q), g(p, q, p, q))));
            if (other[q]) v = add_sat(v, halve(g(p, p, q, q)));
          end
        end
      end
    end
    return v;
  endfunction

  function automatic value_t single_element(logic [15:0] same, logic [15:0] other, int p, int q);
    value_t acc;
    value_t v;
    acc = '0;
    for (int r = 0; r < 16; r++) begin
      if (same[r]) begin
        acc = add_sat(acc, g(p, q, r, r));
        acc = sub_sat(acc, g(p, r, r, q));
      end
      if (other[r]) acc = add_sat(acc, g(p, q, r, r));
    end
    v = add_sat(one_tab[{p[3:0], q[3:0]}], acc);
    return parity_between(same, p, q) ? neg_sat(v) : v;
  endfunction

  function automatic value_t double_element(logic [15:0] l, logic [15:0] rt);
    logic [15:0] occ;
    logic [15:0] vir;
    int p;
    int q;
    int r;
    int s;
    value_t v;
    occ = l & ~rt;
    vir = rt & ~l;
    p = low_index(occ);
    occ[p] = 1'b0;
    r = low_index(occ);
    q = low_index(vir);
    vir[q] = 1'b0;
    s = low_index(vir);
    v = sub_sat(g(p, q, r, s), g(p, s, r, q));
    return (parity_between(l, p, q) != parity_between(rt, r, s)) ? neg_sat(v) : v;
  endfunction

  task automatic apply_word(item_t w);
    result_t res;
    int na;
    int nb;
    int lvl;
    int pa;
    int qa;
    int rb;
    int sb;
    logic [3:0] p;
    logic [3:0] q;
    logic [3:0] r;
    logic [3:0] s;
    p = w.orb_p;
    q = w.orb_q;
    r = w.orb_r;
    s = w.orb_s;
    case (w.kind)
      KIND_LOAD_ONE: begin
        one_tab[{p, q}] = w.integral_value;
        one_tab[{q, p}] = w.integral_value;
      end
      KIND_LOAD_TWO: begin
        two_tab[{p, q, r, s}] = w.integral_value;
        two_tab[{p, q, s, r}] = w.integral_value;
        two_tab[{q, p, r, s}] = w.integral_value;
        two_tab[{q, p, s, r}] = w.integral_value;
        two_tab[{r, s, p, q}] = w.integral_value;
        two_tab[{r, s, q, p}] = w.integral_value;
        two_tab[{s, r, p, q}] = w.integral_value;
        two_tab[{s, r, q, p}] = w.integral_value;
      end
      KIND_COMPUTE: begin
        na = $countones(w.alpha_left & ~w.alpha_right);
        nb = $countones(w.beta_left & ~w.beta_right);
        lvl = na + nb;
        res.count_mismatch = ($countones(w.alpha_left) != $countones(w.alpha_right)) ||
                             ($countones(w.beta_left) != $countones(w.beta_right));
        res.excitation_level = (lvl > 2) ? LEVEL_MANY : 2'(lvl);
        res.matrix_element = '0;
        if (!res.count_mismatch) begin
          if (lvl == 0) begin
            res.matrix_element = diagonal_energy(w.alpha_left, w.beta_left);
          end else if (lvl == 1 && na == 1) begin
            res.matrix_element = single_element(w.alpha_left, w.beta_left,
              low_index(w.alpha_left & ~w.alpha_right), low_index(w.alpha_right & ~w.alpha_left));
          end else if (lvl == 1) begin
            res.matrix_element = single_element(w.beta_left, w.alpha_left,
              low_index(w.beta_left & ~w.beta_right), low_index(w.beta_right & ~w.beta_left));
          end else if (lvl == 2 && na == 2) begin
            res.matrix_element = double_element(w.alpha_left, w.alpha_right);
          end else if (lvl == 2 && nb == 2) begin
            res.matrix_element = double_element(w.beta_left, w.beta_right);
          end else if (lvl == 2) begin
            pa = low_index(w.alpha_left & ~w.alpha_right);
            qa = low_index(w.alpha_right & ~w.alpha_left);
            rb = low_index(w.beta_left & ~w.beta_right);
            sb = low_index(w.beta_right & ~w.beta_left);
            res.matrix_element = g(pa, qa, rb, sb);
            if (parity_between(w.alpha_left, pa, qa) != parity_between(w.beta_left, rb, sb)) begin
              res.matrix_element = neg_sat(res.matrix_element);
            end
          end
        end
        expected_elements.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic int sender_idle_pct();
    return (accepted < 250) ? 37 : (accepted < 500) ? 75 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (accepted < 250) ? 75 : (accepted < 500) ? 37 : 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
    end else begin
      if (item_valid && !item_stall) begin
        apply_word(item);
        accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct() &&
            !(drain_before[0] && expected_elements.size() != 0)) begin
          item <= pending_words.pop_front();
          void'(drain_before.pop_front());
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_elements.size() == 0) begin
          $display("%0t: unexpected word, actual %h/%0d/%0b", $time, result.matrix_element,
                   result.excitation_level, result.count_mismatch);
          errors++;
        end else begin
          want = expected_elements.pop_front();
          checked++;
          level_seen[want.excitation_level]++;
          if (result.matrix_element !== want.matrix_element) begin
            $display("%0t: matrix_element expected %h actual %h", $time,
                     want.matrix_element, result.matrix_element);
            errors++;
          end
          if (result.excitation_level !== want.excitation_level) begin
            $display("%0t: excitation_level expected %0d actual %0d", $time,
                     want.excitation_level, result.excitation_level);
            errors++;
          end
          if (result.count_mismatch !== want.count_mismatch) begin
            $display("%0t: count_mismatch expected %0b actual %0b", $time,
                     want.count_mismatch, result.count_mismatch);
            errors++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] random_mask();
    logic [15:0] m;
    int n;
    m = '0;
    n = ($urandom_range(9) == 0) ? $urandom_range(16) : $urandom_range(5);
    repeat (n) m[$urandom_range(15)] = 1'b1;
    return m;
  endfunction

  function automatic logic [15:0] move_bit(logic [15:0] m);
    int i;
    int j;
    if (m == '0 || m == 16'hFFFF) return m;
    do i = $urandom_range(15); while (!m[i]);
    do j = $urandom_range(15); while (m[j]);
    m[i] = 1'b0;
    m[j] = 1'b1;
    return m;
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(9))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2, 3: return {$urandom, $urandom};
      default: return value_t'($signed({$urandom_range(255), $urandom}) - 64'sd549755813888);
    endcase
  endfunction

  function automatic item_t base_word(logic [1:0] kind);
    item_t w;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(item_t)-1:0];
    w.kind = kind;
    w.integral_value = random_value();
    return w;
  endfunction

  function automatic item_t load_word(logic [1:0] kind, int p, int q, int r, int s, value_t v);
    item_t w;
    w = base_word(kind);
    w.orb_p = ORB_W'(p);
    w.orb_q = ORB_W'(q);
    w.orb_r = ORB_W'(r);
    w.orb_s = ORB_W'(s);
    w.integral_value = v;
    return w;
  endfunction

  function automatic item_t compute_word(logic [15:0] al, logic [15:0] bl, logic [15:0] ar,
                                         logic [15:0] br);
    item_t w;
    w = base_word(KIND_COMPUTE);
    w.alpha_left = al;
    w.beta_left = bl;
    w.alpha_right = ar;
    w.beta_right = br;
    return w;
  endfunction

  function automatic item_t random_compute();
    logic [15:0] al;
    logic [15:0] bl;
    logic [15:0] ar;
    logic [15:0] br;
    al = random_mask();
    bl = random_mask();
    ar = al;
    br = bl;
    case ($urandom_range(9))
      1: ar = move_bit(al);
      2: br = move_bit(bl);
      3: ar = move_bit(move_bit(al));
      4: br = move_bit(move_bit(bl));
      5: begin
        ar = move_bit(al);
        br = move_bit(bl);
      end
      6: begin
        ar = move_bit(move_bit(al));
        br = move_bit(move_bit(bl));
      end
      7: begin
        ar[$urandom_range(15)] ^= 1'b1;
        br = move_bit(bl);
      end
      8: begin
        ar = random_mask();
        br = random_mask();
      end
      default: ;
    endcase
    return compute_word(al, bl, ar, br);
  endfunction

  task automatic queue_word(item_t w, bit hold);
    pending_words.push_back(w);
    drain_before.push_back(hold);
  endtask

  initial begin
    item_t w;
    foreach (one_tab[i]) one_tab[i] = '0;
    foreach (two_tab[i]) two_tab[i] = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_word(load_word(KIND_LOAD_ONE, 0, 0, 0, 0, VALUE_MAX), 0);
    queue_word(load_word(KIND_LOAD_ONE, 15, 3, 0, 0, VALUE_MIN), 0);
    queue_word(load_word(KIND_LOAD_TWO, 0, 0, 0, 0, VALUE_MAX), 0);
    queue_word(load_word(KIND_LOAD_TWO, 15, 14, 13, 12, VALUE_MIN), 0);
    queue_word(load_word(KIND_LOAD_TWO, 1, 2, 3, 4, random_value()), 0);
    queue_word(load_word(KIND_LOAD_TWO, 1, 1, 5, 5, random_value()), 0);
    queue_word(load_word(KIND_LOAD_ONE, 7, 7, 0, 0, random_value()), 0);
    queue_word(base_word(KIND_UNUSED), 0);
    queue_word(compute_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
    queue_word(compute_word(16'h0000, 16'h0000, 16'h0000, 16'h0000), 0);
    queue_word(compute_word(16'h8001, 16'h0000, 16'h8008, 16'h0000), 0);
    queue_word(compute_word(16'h0022, 16'h0012, 16'h0022, 16'h0018), 0);
    queue_word(compute_word(16'h0106, 16'h0001, 16'h0018, 16'h0001), 0);
    queue_word(compute_word(16'h0001, 16'hC003, 16'h0001, 16'h3030), 0);
    queue_word(compute_word(16'h0006, 16'h0012, 16'h000C, 16'h0018), 0);
    queue_word(compute_word(16'h0007, 16'h0001, 16'h0038, 16'h0001), 0);
    queue_word(compute_word(16'h0003, 16'h0001, 16'h0001, 16'h0001), 0);
    queue_word(compute_word(16'h0000, 16'hFFFF, 16'h0000, 16'h0000), 0);
    queue_word(compute_word(16'h00A1, 16'h0081, 16'h00A1, 16'h0081), 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(19))
        0, 1, 2: w = load_word(KIND_LOAD_TWO, $urandom_range(15), $urandom_range(15),
                               $urandom_range(15), $urandom_range(15), random_value());
        3, 4: w = load_word(KIND_LOAD_ONE, $urandom_range(15), $urandom_range(15), 0, 0,
                            random_value());
        5: w = base_word(KIND_UNUSED);
        default: w = random_compute();
      endcase
      queue_word(w, n == 350);
    end

    wait (pending_words.size() == 0);
    @(posedge clk);
    while (item_valid || expected_elements.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Accepted %0d words and checked %0d elements across three idling phases.",
             accepted, checked);
    $display("Levels seen: %0d diagonal, %0d single, %0d double, %0d beyond.",
             level_seen[0], level_seen[1], level_seen[2], level_seen[3]);
    if (errors == 0 && expected_elements.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/scme_pkg.sv
design/scme_ram.sv
design/scme_front.sv
design/scme_queue.sv
design/scme_back.sv
design/slater_condon_matrix_element.sv
design/scme_checker.sv
verif/tb_top.sv
